/* rtl/core/smpq_pkg.sv */
//------------------------------------------------------------------------------
// smpq_pkg
// Shared constants and types for the stable max priority queue.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package smpq_pkg;
	localparam int CAPACITY = 64;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int KW = 32;
	localparam int TW = 16;
	localparam int EW = KW + TW;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SERVE  = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic load;       // latch input item
		logic scan_start; // reset scan pointers
		logic scan_step;  // advance scan by one entry
		logic ins_wr;     // write new entry at fill count
		logic shift_step; // move entry down by one slot
		logic finish;     // publish result
		logic clear;      // empty the queue
	} smpq_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       empty;
		logic       full;
		logic       scan_done;
		logic       shift_done;
	} smpq_sts_t;
endpackage
`default_nettype wire

/* rtl/core/smpq_ram.sv */
//------------------------------------------------------------------------------
// smpq_ram
// Generic single-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module smpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* rtl/core/smpq_datapath.sv */
//------------------------------------------------------------------------------
// smpq_datapath
// Entry store, max scan with earliest-wins ties, and gap-closing shift.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module smpq_datapath import smpq_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	input  smpq_cmd_t        cmd,
	output smpq_sts_t        sts,
	input  wire [1:0]        operation,
	input  wire [KW-1:0]     urgency,
	input  wire [TW-1:0]     tag,
	output logic [1:0]       status,
	output logic [TW-1:0]    served_tag,
	output logic [KW-1:0]    served_urgency,
	output logic [6:0]       entries_held
);
	logic [1:0]    op_q;
	logic [KW-1:0] key_q;
	logic [TW-1:0] tag_q;
	logic          was_full_q; // store full when the item was taken
	logic [CW-1:0] fill_q;
	logic [CW-1:0] rd_q;     // next address presented to RAM
	logic [CW-1:0] idx_q;    // address whose data is on rdata
	logic          idx_vld_q;
	logic [AW-1:0] best_q;
	logic [EW-1:0] best_e_q;
	logic          have_q;
	logic [EW-1:0] rdata;
	logic          we;
	logic [AW-1:0] waddr;
	logic [EW-1:0] wdata;
	logic          empty, full;
	logic          take;     // entry on rdata beats the current best

	assign empty = (fill_q == '0);
	assign full  = (fill_q == CW'(CAPACITY));
	// strict compare keeps the earliest of equal keys
	assign take  = !have_q || (rdata[EW-1:TW] > best_e_q[EW-1:TW]);

	smpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(rd_q[AW-1:0]), .rdata(rdata)
	);

	// During shift, rdata holds entry idx_q; write it to idx_q-1.
	always_comb begin
		we    = 1'b0;
		waddr = fill_q[AW-1:0];
		wdata = {key_q, tag_q};
		if (cmd.ins_wr) begin
			we = 1'b1;
		end else if (cmd.shift_step && idx_vld_q) begin
			we    = 1'b1;
			waddr = AW'(idx_q - 1'b1);
			wdata = rdata;
		end
	end

	assign sts.op         = op_q;
	assign sts.empty      = empty;
	assign sts.full       = full;
	assign sts.scan_done  = idx_vld_q && (idx_q + 1'b1 >= fill_q);
	// no more slots to read: the write this cycle, if any, is the last
	assign sts.shift_done = (rd_q >= fill_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			idx_vld_q <= 1'b0;
			have_q    <= 1'b0;
			rd_q      <= '0;
			idx_q     <= '0;
			was_full_q <= 1'b0;
			status         <= ST_OK;
			served_tag     <= '0;
			served_urgency <= '0;
			entries_held   <= '0;
		end else begin
			if (cmd.load) begin
				op_q       <= operation;
				key_q      <= urgency;
				tag_q      <= tag;
				was_full_q <= full;
			end
			if (cmd.scan_start) begin
				rd_q      <= '0;
				idx_vld_q <= 1'b0;
				have_q    <= 1'b0;
			end else if (cmd.scan_step) begin
				if (sts.scan_done) begin
					// restart reads at the slot after the winner
					idx_vld_q <= 1'b0;
					have_q    <= 1'b1;
					if (take) begin
						best_q   <= idx_q[AW-1:0];
						best_e_q <= rdata;
						rd_q     <= idx_q + 1'b1;
					end else begin
						rd_q <= CW'(best_q) + 1'b1;
					end
				end else begin
					rd_q      <= rd_q + 1'b1;
					idx_q     <= rd_q;
					idx_vld_q <= 1'b1;
					if (idx_vld_q && take) begin
						best_q   <= idx_q[AW-1:0];
						best_e_q <= rdata;
						have_q   <= 1'b1;
					end
				end
			end else if (cmd.shift_step) begin
				rd_q      <= rd_q + 1'b1;
				idx_q     <= rd_q;
				idx_vld_q <= (rd_q < fill_q);
			end
			if (cmd.ins_wr) begin
				fill_q <= fill_q + 1'b1;
			end else if (cmd.clear) begin
				fill_q <= '0;
			end else if (cmd.finish && op_q == OP_SERVE && !empty) begin
				fill_q <= fill_q - 1'b1;
			end
			if (cmd.finish) begin
				unique case (op_q)
					OP_INSERT: begin
						status         <= was_full_q ? ST_FULL : ST_OK;
						served_tag     <= '0;
						served_urgency <= '0;
						entries_held   <= 7'(fill_q);
					end
					OP_SERVE: begin
						if (empty) begin
							status         <= ST_EMPTY;
							served_tag     <= '0;
							served_urgency <= '0;
							entries_held   <= 7'(fill_q);
						end else begin
							status         <= ST_OK;
							served_urgency <= best_e_q[EW-1:TW];
							served_tag     <= best_e_q[TW-1:0];
							entries_held   <= 7'(fill_q - 1'b1);
						end
					end
					default: begin
						status         <= ST_OK;
						served_tag     <= '0;
						served_urgency <= '0;
						entries_held   <= 7'(fill_q);
					end
				endcase
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/core/smpq_ctrl.sv */
//------------------------------------------------------------------------------
// smpq_ctrl
// Sequencer for insert, serve (scan then shift) and clear.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module smpq_ctrl import smpq_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire        out_stall,
	output logic       out_valid,
	input  smpq_sts_t  sts,
	output smpq_cmd_t  cmd
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DEC   = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;

	assign out_valid = out_valid_q;
	// take a new item only with the result slot free or leaving
	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && !in_stall) begin
					cmd.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				cmd.scan_start = 1'b1;
				state_d = S_FIN;
				if (sts.op == OP_INSERT && !sts.full) cmd.ins_wr = 1'b1;
				if (sts.op == OP_CLEAR) cmd.clear = 1'b1;
				if (sts.op == OP_SERVE && !sts.empty) state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) state_d = S_SHIFT;
			end
			S_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (sts.shift_done) state_d = S_FIN;
			end
			S_FIN: begin
				if (!(out_valid_q && out_stall)) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

/* rtl/core/stable_max_priority_queue_top.sv */
//------------------------------------------------------------------------------
// stable_max_priority_queue_top
// Max priority queue of (urgency, tag) entries, earliest first on equal keys.
//------------------------------------------------------------------------------
// Insert, clear and bad-op items pass IDLE, DEC and FIN from accept to result.
// Serve adds a scan and a shift: one RAM read per entry to find the max,
// then one read/write per entry past the winner to close the gap (1R1W RAM).
// One item in flight; the next is taken once the result slot is free or drained.
// Reset empties the queue (fill count to zero); RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module stable_max_priority_queue_top import smpq_pkg::*; (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_stall,
	input  wire [1:0]      operation,
	input  wire [KW-1:0]   urgency,
	input  wire [TW-1:0]   tag,
	output logic           out_valid,
	input  wire            out_stall,
	output logic [1:0]     status,
	output logic [TW-1:0]  served_tag,
	output logic [KW-1:0]  served_urgency,
	output logic [6:0]     entries_held
);
	smpq_cmd_t cmd;
	smpq_sts_t sts;

	// Sequencer: decodes each item and steps the datapath.
	smpq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_stall(out_stall), .out_valid(out_valid),
		.sts(sts), .cmd(cmd)
	);

	// Datapath: entry RAM in arrival order, scan and shift logic, result regs.
	smpq_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.operation(operation), .urgency(urgency), .tag(tag),
		.status(status), .served_tag(served_tag),
		.served_urgency(served_urgency), .entries_held(entries_held)
	);
endmodule
`default_nettype wire
